/* hw/rtl/lal_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and elaboration-time tables for the log-average luminance block.
// No dependencies; every other file in hw/rtl refers to it by scoped names.
package lal_pkg;

	// Field and datapath widths
	localparam int PIX_W           = 16;
	localparam int PIXEL_FRAC_BITS = 8;
	localparam int LOG_FRAC_BITS   = 12;
	localparam int MAX_DIM         = 4096;
	localparam int DIM_W           = 13;
	localparam int N_W             = 25;
	localparam int SUM_W           = 40;
	localparam int CNT_W           = 24;
	localparam int X_W             = PIX_W + 1;
	localparam int EXPO_W          = $clog2(X_W);
	localparam int LOGV_W          = EXPO_W + 1 + LOG_FRAC_BITS;
	localparam int MANT_W          = 32;
	localparam int PROD_W          = 32;
	localparam int T_W             = SUM_W + 2;
	localparam int SH_W            = 6;
	localparam int STEP_W          = $clog2(SUM_W);
	localparam int ROOT_IDX_W      = $clog2(LOG_FRAC_BITS);
	localparam int QUEUE_DEPTH     = 4;
	localparam int TDATA_IN_W      = 3 * PIX_W;

	// Luminance coefficients, 16 fraction bits
	localparam int COEF_FRAC_BITS = 16;
	localparam int COEF_R         = 13933;
	localparam int COEF_G         = 46871;
	localparam int COEF_B         = 4732;
	localparam int ROUND_HALF     = 1 << (COEF_FRAC_BITS - 1);

	// exp2 product format is Q2.30
	localparam int EXP_FRAC_BITS = 30;
	localparam int EXP_SAT_INT   = 16;
	localparam int SHIFT_LIMIT   = 63;
	localparam int LOG_OFFSET    = PIXEL_FRAC_BITS << LOG_FRAC_BITS;

	// Register reset values
	localparam int RESET_WIDTH  = 1920;
	localparam int RESET_HEIGHT = 1080;

	// Configuration register indexes
	localparam int CFG_IDX_W = 1;
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} cfg_reg_t;

	// Back-end sequencer states
	typedef enum logic [2:0] {
		BK_IDLE,
		BK_LOG,
		BK_ACC,
		BK_DIV,
		BK_PREP,
		BK_EXP,
		BK_FIN
	} back_state_t;

	// One queued luminance value (lum + 1) with its valid flag
	typedef struct packed {
		logic           vld;
		logic [X_W-1:0] x;
	} lum_entry_t;

	typedef logic [LOG_FRAC_BITS-1:0][MANT_W-1:0] root_tab_t;

	// Bit-by-bit integer square root, used only at elaboration
	function automatic logic [63:0] isqrt64(input logic [63:0] v);
		logic [63:0] val;
		logic [63:0] res;
		logic [63:0] bt;
		val = v;
		res = '0;
		bt  = 64'd1 << 62;
		for (int k = 0; k < 32; k++) begin
			if (val >= res + bt) begin
				val = val - (res + bt);
				res = (res >> 1) + bt;
			end else begin
				res = res >> 1;
			end
			bt = bt >> 2;
		end
		return res;
	endfunction

	// Repeated square roots of two in Q2.30: 2^(2^-(k+1)) for k = 0, 1, ...
	function automatic root_tab_t gen_roots();
		root_tab_t   tab;
		logic [63:0] c;
		c = isqrt64(64'd1 << (2 * EXP_FRAC_BITS + 1));
		tab[0] = c[MANT_W-1:0];
		for (int k = 1; k < LOG_FRAC_BITS; k++) begin
			c = isqrt64(c << EXP_FRAC_BITS);
			tab[k] = c[MANT_W-1:0];
		end
		return tab;
	endfunction

	localparam root_tab_t ROOT_TAB = gen_roots();

	// Clamp a frame dimension to 1..MAX_DIM
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
		logic [DIM_W-1:0] r;
		r = d;
		if (d == '0) r = DIM_W'(1);
		else if (d > DIM_W'(MAX_DIM)) r = DIM_W'(MAX_DIM);
		return r;
	endfunction

endpackage

/* hw/rtl/lal_front.sv */
`timescale 1ns / 1ps
// Front end: takes RGB pixels and forms Rec.709 luminance plus one LSB in two stages.
// Depends on lal_pkg; feeds lal_queue.
module lal_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [lal_pkg::TDATA_IN_W-1:0]      s_tdata,  // red, green, blue from bit 0 up
	input  logic                                q_full,
	output lal_pkg::lum_entry_t                 push
);

	logic                        en;
	logic                        valid_s1;
	logic                        valid_s2;
	logic [lal_pkg::PROD_W-1:0]  prod_r_s1;
	logic [lal_pkg::PROD_W-1:0]  prod_g_s1;
	logic [lal_pkg::PROD_W-1:0]  prod_b_s1;
	logic [lal_pkg::PROD_W-1:0]  sum_s2;

	// Advance the pipe unless the last stage holds an item the queue cannot take
	assign en       = !(valid_s2 && q_full);
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= s_tvalid;
			valid_s2 <= valid_s1;
		end
	end

	// Stage 1: weight each channel
	always_ff @(posedge clk) begin
		if (en) begin
			prod_r_s1 <= lal_pkg::PROD_W'(s_tdata[lal_pkg::PIX_W-1:0])
				* lal_pkg::PROD_W'(lal_pkg::COEF_R);
			prod_g_s1 <= lal_pkg::PROD_W'(s_tdata[2*lal_pkg::PIX_W-1:lal_pkg::PIX_W])
				* lal_pkg::PROD_W'(lal_pkg::COEF_G);
			prod_b_s1 <= lal_pkg::PROD_W'(s_tdata[3*lal_pkg::PIX_W-1:2*lal_pkg::PIX_W])
				* lal_pkg::PROD_W'(lal_pkg::COEF_B);
		end
	end

	// Stage 2: sum with rounding; coefficients add to 2^16 so 32 bits never overflow
	always_ff @(posedge clk) begin
		if (en) begin
			sum_s2 <= prod_r_s1 + prod_g_s1 + prod_b_s1
				+ lal_pkg::PROD_W'(lal_pkg::ROUND_HALF);
		end
	end

	// Drop the fraction and add the epsilon LSB
	assign push.vld = valid_s2 && !q_full;
	assign push.x   = lal_pkg::X_W'(sum_s2[lal_pkg::PROD_W-1:lal_pkg::COEF_FRAC_BITS])
		+ lal_pkg::X_W'(1);

endmodule

/* hw/rtl/lal_queue.sv */
`timescale 1ns / 1ps
// Short FIFO of luminance values between the front end and the log/accumulate back end.
// Depends on lal_pkg.
module lal_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  lal_pkg::lum_entry_t push,
	output logic                full,
	input  logic                pop,
	output lal_pkg::lum_entry_t head
);

	localparam int PTR_W = $clog2(lal_pkg::QUEUE_DEPTH);
	localparam int CNT_W = $clog2(lal_pkg::QUEUE_DEPTH + 1);

	logic [lal_pkg::X_W-1:0] mem_q [lal_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0]        wr_ptr_q;
	logic [PTR_W-1:0]        rd_ptr_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    do_pop;

	assign full     = (cnt_q == CNT_W'(lal_pkg::QUEUE_DEPTH));
	assign head.vld = (cnt_q != '0);
	assign head.x   = mem_q[rd_ptr_q];
	assign do_pop   = pop && head.vld;

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push.vld) wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			if (do_pop) rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			if (push.vld && !do_pop) cnt_q <= cnt_q + CNT_W'(1);
			else if (!push.vld && do_pop) cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (push.vld) mem_q[wr_ptr_q] <= push.x;
	end

endmodule

/* hw/rtl/lal_back.sv */
`timescale 1ns / 1ps
// Back end: iterative log2, saturating accumulation, frame-end divide and exp2, output register.
// Depends on lal_pkg; takes items from lal_queue.
module lal_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lal_pkg::lum_entry_t           head,
	output logic                          pop,
	input  logic [lal_pkg::N_W-1:0]       total,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [lal_pkg::PIX_W-1:0]     m_tdata   // avg_luminance
);

	localparam int SUM_W  = lal_pkg::SUM_W;
	localparam int MANT_W = lal_pkg::MANT_W;
	localparam int LFB    = lal_pkg::LOG_FRAC_BITS;
	localparam int STEP_W = lal_pkg::STEP_W;
	localparam int T_W    = lal_pkg::T_W;
	localparam int I_W    = T_W - LFB;
	localparam logic [STEP_W-1:0] LOG_LAST = STEP_W'(LFB - 1);
	localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(SUM_W - 1);

	lal_pkg::back_state_t state_q;
	lal_pkg::back_state_t state_d;

	logic [STEP_W-1:0]                step_q;
	logic [MANT_W-1:0]                mant_q;
	logic [LFB-1:0]                   frac_q;
	logic [lal_pkg::EXPO_W-1:0]       expo_q;
	logic signed [SUM_W-1:0]          log_sum_q;
	logic [lal_pkg::CNT_W-1:0]        count_q;
	logic [SUM_W-1:0]                 quot_q;
	logic [lal_pkg::N_W-1:0]          rem_q;
	logic                             neg_q;
	logic                             sat_q;
	logic                             zero_q;
	logic [lal_pkg::SH_W-1:0]         sh_q;
	logic                             out_valid_q;
	logic [lal_pkg::PIX_W-1:0]        out_data_q;

	logic                             out_free;
	logic                             out_load;
	logic [lal_pkg::EXPO_W-1:0]       expo;
	logic [MANT_W-1:0]                mant_init;
	logic [MANT_W-1:0]                mul_b;
	logic [2*MANT_W-1:0]              prod;
	logic [MANT_W:0]                  sq;
	logic [2*MANT_W-1:0]              exp_round;
	logic signed [lal_pkg::EXPO_W:0]  ipart;
	logic signed [lal_pkg::LOGV_W-1:0] logv;
	logic signed [SUM_W:0]            sum_wide;
	logic signed [SUM_W-1:0]          sum_sat;
	logic [SUM_W-1:0]                 sum_mag;
	logic [lal_pkg::CNT_W:0]          count_next;
	logic                             frame_end;
	logic [lal_pkg::N_W:0]            rem_sh;
	logic                             div_ge;
	logic [lal_pkg::N_W:0]            rem_nx;
	logic signed [T_W-1:0]            mean;
	logic signed [T_W-1:0]            t_val;
	logic signed [I_W-1:0]            i_val;
	logic signed [I_W-1:0]            sh_full;
	logic [MANT_W-1:0]                shifted;
	logic [lal_pkg::PIX_W-1:0]        result;

	assign out_free = !out_valid_q || m_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// Leading-one position of the queued value
	always_comb begin
		expo = '0;
		for (int k = 1; k < lal_pkg::X_W; k++) begin
			if (head.x[k]) expo = lal_pkg::EXPO_W'(k);
		end
	end
	assign mant_init = MANT_W'(head.x) << (lal_pkg::EXPO_W'(MANT_W - 1) - expo);

	// Shared multiplier: squaring for log2, root product for exp2
	assign mul_b     = (state_q == lal_pkg::BK_LOG) ? mant_q
		: lal_pkg::ROOT_TAB[step_q[lal_pkg::ROOT_IDX_W-1:0]];
	assign prod      = (2*MANT_W)'(mant_q) * (2*MANT_W)'(mul_b);
	assign sq        = prod[2*MANT_W-1:MANT_W-1];
	assign exp_round = prod + ((2*MANT_W)'(1) << (lal_pkg::EXP_FRAC_BITS - 1));

	// Log value and saturating sum
	assign ipart      = signed'({1'b0, expo_q}) - (lal_pkg::EXPO_W+1)'(lal_pkg::PIXEL_FRAC_BITS);
	assign logv       = {ipart, frac_q};
	assign sum_wide   = (SUM_W+1)'(log_sum_q) + (SUM_W+1)'(logv);
	always_comb begin
		sum_sat = sum_wide[SUM_W-1:0];
		if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
			sum_sat = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
		end
	end
	assign sum_mag    = sum_sat[SUM_W-1] ? SUM_W'(-sum_sat) : SUM_W'(sum_sat);
	assign count_next = (lal_pkg::CNT_W+1)'(count_q) + (lal_pkg::CNT_W+1)'(1);
	assign frame_end  = (count_next >= total);

	// Restoring divide step
	assign rem_sh = {rem_q, quot_q[SUM_W-1]};
	assign div_ge = (rem_sh >= (lal_pkg::N_W+1)'(total));
	assign rem_nx = div_ge ? (rem_sh - (lal_pkg::N_W+1)'(total)) : rem_sh;

	// Floor of the mean, exponent offset and split into integer and fraction
	always_comb begin
		if (neg_q) mean = -(T_W'(quot_q) + T_W'(rem_q != '0));
		else mean = T_W'(quot_q);
	end
	assign t_val   = mean + T_W'(lal_pkg::LOG_OFFSET);
	assign i_val   = t_val[T_W-1:LFB];
	assign sh_full = I_W'(lal_pkg::EXP_FRAC_BITS) - i_val;

	// Scale and saturate the exp2 product
	assign shifted = mant_q >> sh_q;
	always_comb begin
		if (sat_q) result = '1;
		else if (zero_q) result = '0;
		else if (shifted[MANT_W-1:lal_pkg::PIX_W] != '0) result = '1;
		else result = shifted[lal_pkg::PIX_W-1:0];
	end

	// Sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= lal_pkg::BK_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		pop      = 1'b0;
		out_load = 1'b0;
		case (state_q)
			lal_pkg::BK_IDLE: begin
				if (head.vld) begin
					pop     = 1'b1;
					state_d = lal_pkg::BK_LOG;
				end
			end
			lal_pkg::BK_LOG: begin
				if (step_q == LOG_LAST) state_d = lal_pkg::BK_ACC;
			end
			lal_pkg::BK_ACC: begin
				state_d = frame_end ? lal_pkg::BK_DIV : lal_pkg::BK_IDLE;
			end
			lal_pkg::BK_DIV: begin
				if (step_q == DIV_LAST) state_d = lal_pkg::BK_PREP;
			end
			lal_pkg::BK_PREP: begin
				state_d = lal_pkg::BK_EXP;
			end
			lal_pkg::BK_EXP: begin
				if (step_q == LOG_LAST) state_d = lal_pkg::BK_FIN;
			end
			lal_pkg::BK_FIN: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = lal_pkg::BK_IDLE;
				end
			end
			default: state_d = lal_pkg::BK_IDLE;
		endcase
	end

	// Step counter, frame state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= '0;
			log_sum_q   <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			step_q <= (state_d == state_q) ? step_q + STEP_W'(1) : '0;
			if (state_q == lal_pkg::BK_ACC) begin
				if (frame_end) begin
					log_sum_q <= '0;
					count_q   <= '0;
				end else begin
					log_sum_q <= sum_sat;
					count_q   <= count_next[lal_pkg::CNT_W-1:0];
				end
			end
			if (out_load) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		case (state_q)
			lal_pkg::BK_IDLE: begin
				mant_q <= mant_init;
				expo_q <= expo;
				frac_q <= '0;
			end
			lal_pkg::BK_LOG: begin
				if (sq[MANT_W]) begin
					mant_q <= sq[MANT_W:1];
					frac_q <= {frac_q[LFB-2:0], 1'b1};
				end else begin
					mant_q <= sq[MANT_W-1:0];
					frac_q <= {frac_q[LFB-2:0], 1'b0};
				end
			end
			lal_pkg::BK_ACC: begin
				neg_q  <= sum_sat[SUM_W-1];
				quot_q <= sum_mag;
				rem_q  <= '0;
			end
			lal_pkg::BK_DIV: begin
				rem_q  <= rem_nx[lal_pkg::N_W-1:0];
				quot_q <= {quot_q[SUM_W-2:0], div_ge};
			end
			lal_pkg::BK_PREP: begin
				frac_q <= t_val[LFB-1:0];
				mant_q <= MANT_W'(1) << lal_pkg::EXP_FRAC_BITS;
				sat_q  <= (i_val >= I_W'(lal_pkg::EXP_SAT_INT));
				zero_q <= (sh_full >= I_W'(lal_pkg::SHIFT_LIMIT));
				sh_q   <= sh_full[lal_pkg::SH_W-1:0];
			end
			lal_pkg::BK_EXP: begin
				if (frac_q[LFB-1]) mant_q <= exp_round[MANT_W+lal_pkg::EXP_FRAC_BITS-1:
					lal_pkg::EXP_FRAC_BITS];
				frac_q <= {frac_q[LFB-2:0], 1'b0};
			end
			lal_pkg::BK_FIN: begin
				if (out_load) out_data_q <= result;
			end
			default: begin
			end
		endcase
	end

endmodule

/* hw/rtl/log_average_luminance.sv */
`timescale 1ns / 1ps
// Top level of the log-average (geometric mean) luminance block.
// Depends on lal_pkg, lal_front, lal_queue and lal_back.
//
// Usage:
//   Pixels enter on the s_ channel, one RGB pixel per transaction, each channel
//   unsigned with 8 fraction bits. After frame_width * frame_height pixels (each
//   dimension clamped to 1..4096) one transaction leaves on the m_ channel with the
//   geometric mean luminance, 8 fraction bits, saturated to 16 bits; the running
//   sum and pixel count then clear for the next frame.
//   Frame size is set through cfg_wen / cfg_index / cfg_wdata; the user must write it
//   only while the block is idle, which the block itself does not enforce. Writes do
//   not clear a frame in progress. Throughput: the front end takes one pixel per cycle
//   into a four-entry queue while the queue has room; the back end takes a new pixel
//   only after the log2 and accumulation of the last one, paced by the 12 squaring
//   steps of the log2 on the shared 32x32 multiplier. A frame end adds a 40-step
//   restoring divide, a setup state, 12 exp2 steps and the output load.
//   Reset clears the frame sum, pixel count and queue and restores 1920 x 1080.
//   When m_tready is low the result holds in the output register; the back end
//   keeps accepting pixels and stalls only at the next frame end.
module log_average_luminance (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [lal_pkg::TDATA_IN_W-1:0]     s_tdata,   // red, green, blue from bit 0 up
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [lal_pkg::PIX_W-1:0]          m_tdata,   // avg_luminance
	input  logic                               cfg_wen,
	input  logic [lal_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [lal_pkg::DIM_W-1:0]          cfg_wdata
);

	logic [lal_pkg::DIM_W-1:0] width_q;
	logic [lal_pkg::DIM_W-1:0] height_q;
	logic [lal_pkg::N_W-1:0]   total_q;
	lal_pkg::lum_entry_t       push;
	lal_pkg::lum_entry_t       head;
	logic                      q_full;
	logic                      pop;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= lal_pkg::DIM_W'(lal_pkg::RESET_WIDTH);
			height_q <= lal_pkg::DIM_W'(lal_pkg::RESET_HEIGHT);
		end else if (cfg_wen) begin
			case (lal_pkg::cfg_reg_t'(cfg_index))
				lal_pkg::REG_FRAME_WIDTH:  width_q  <= cfg_wdata;
				lal_pkg::REG_FRAME_HEIGHT: height_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// Frame size in pixels from the clamped dimensions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= lal_pkg::N_W'(lal_pkg::RESET_WIDTH * lal_pkg::RESET_HEIGHT);
		end else begin
			total_q <= lal_pkg::N_W'(lal_pkg::clamp_dim(width_q))
				* lal_pkg::N_W'(lal_pkg::clamp_dim(height_q));
		end
	end

	lal_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_full   (q_full),
		.push     (push)
	);

	lal_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (q_full),
		.pop    (pop),
		.head   (head)
	);

	lal_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.pop      (pop),
		.total    (total_q),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

/* hw/rtl/lal_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for log_average_luminance, attached with a bind below.
// Depends on lal_pkg.
module lal_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      s_tvalid,
	input logic                      s_tready,
	input logic                      m_tvalid,
	input logic                      m_tready,
	input logic [lal_pkg::PIX_W-1:0] m_tdata
);

	// Fewer cycles than the shortest path from first pixel to first result
	localparam int MIN_LATENCY = 40;

	logic seen_input_q;

	// Remember that at least one pixel transaction has happened
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) seen_input_q <= 1'b0;
		else if (s_tvalid && s_tready) seen_input_q <= 1'b1;
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed or dropped while stalled");

	a_out_has_cause: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> seen_input_q)
		else $error("result without any pixel taken");

	a_out_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(seen_input_q, MIN_LATENCY))
		else $error("first result arrived faster than the log/divide/exp path allows");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!seen_input_q |-> s_tready)
		else $error("input stalled with nothing in flight");

endmodule

bind log_average_luminance lal_checker u_lal_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
